### rtl/lcc_pkg.sv
// Shared constants, codes and control types for the Luhn card number classifier.
// Used by lcc_controller, lcc_datapath and luhn_card_number_classifier_top.
package lcc_pkg;

  localparam int CARD_W      = 63;
  localparam int BIN_W       = 64;
  localparam int DIGITS      = 19;
  localparam int BCD_W       = DIGITS * 4;
  localparam int STEP_BITS   = 4;
  localparam int CONV_CYCLES = BIN_W / STEP_BITS;
  localparam int CONV_CNT_W  = $clog2(CONV_CYCLES);
  localparam int COUNT_W     = 5;
  localparam int CLASS_W     = 2;

  localparam logic [CLASS_W-1:0] CLS_NONE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_34_37 = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_51_55 = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_LEAD4 = 2'd3;

  localparam logic [COUNT_W-1:0] LEN_13  = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15  = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16  = 5'd16;
  localparam logic [COUNT_W-1:0] LEN_MAX = 5'd19;

  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
  } lcc_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lcc_status_t;

endpackage

### rtl/luhn_card_number_classifier_top.sv
// Top level of the Luhn card number classifier.
// Depends on lcc_pkg, lcc_controller and lcc_datapath.
//
// Usage: drive card_number and pulse start while busy is low; the number is
// transferred at that rising edge. busy stays high until the result is out.
// The result (issuer_class, luhn_ok, digit_count) is valid for exactly one
// cycle while done is high; the receiver cannot stall and must take it then.
// Operation: the number is turned into BCD four bits a cycle, then the digits
// are scanned one a cycle from the least significant end until none remain,
// then done is raised. A new number is taken only in idle, after done; the
// BCD shift-add loop and the per-digit scan set how long one number takes.
// Reset: synchronous rst returns the sequencer to idle, drops busy and done,
// and abandons any number in progress; no result is issued for it.
module luhn_card_number_classifier_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [lcc_pkg::CARD_W-1:0]  card_number,
  output logic                        done,
  output logic [lcc_pkg::CLASS_W-1:0] issuer_class,
  output logic                        luhn_ok,
  output logic [lcc_pkg::COUNT_W-1:0] digit_count
);

  lcc_pkg::lcc_cmd_t    cmd;
  lcc_pkg::lcc_status_t status;

  lcc_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  lcc_datapath u_dp (
    .clk          (clk),
    .card_number  (card_number),
    .cmd          (cmd),
    .status       (status),
    .issuer_class (issuer_class),
    .luhn_ok      (luhn_ok),
    .digit_count  (digit_count)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_class_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (done && issuer_class != lcc_pkg::CLS_NONE) |-> luhn_ok)
    else $error("issuer class given for number failing the check");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> digit_count <= lcc_pkg::LEN_MAX)
    else $error("digit count out of range");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");
`endif

endmodule

### rtl/lcc_datapath.sv
// Datapath: binary to BCD conversion, digit scan with Luhn sum, prefix and class.
// Depends on lcc_pkg; driven by lcc_controller through lcc_cmd_t.
module lcc_datapath (
  input  logic                          clk,
  input  logic [lcc_pkg::CARD_W-1:0]    card_number,
  input  lcc_pkg::lcc_cmd_t             cmd,
  output lcc_pkg::lcc_status_t          status,
  output logic [lcc_pkg::CLASS_W-1:0]   issuer_class,
  output logic                          luhn_ok,
  output logic [lcc_pkg::COUNT_W-1:0]   digit_count
);

  function automatic logic [lcc_pkg::BCD_W-1:0] dabble_step(
    input logic [lcc_pkg::BCD_W-1:0]     b,
    input logic [lcc_pkg::STEP_BITS-1:0] bits
  );
    logic [lcc_pkg::BCD_W-1:0] v;
    v = b;
    for (int k = 0; k < lcc_pkg::STEP_BITS; k++) begin
      for (int i = 0; i < lcc_pkg::DIGITS; i++) begin
        if (v[4*i +: 4] >= 4'd5) begin
          v[4*i +: 4] = v[4*i +: 4] + 4'd3;
        end
      end
      v = {v[lcc_pkg::BCD_W-2:0], bits[lcc_pkg::STEP_BITS-1-k]};
    end
    return v;
  endfunction

  logic [lcc_pkg::BIN_W-1:0]   bin;
  logic [lcc_pkg::BCD_W-1:0]   bcd;
  logic [3:0]                  sum;
  logic [3:0]                  sum_next;
  logic [lcc_pkg::COUNT_W-1:0] count;
  logic [3:0]                  hi;
  logic [3:0]                  lo;
  logic [3:0]                  d;
  logic [4:0]                  dbl;
  logic [4:0]                  v;
  logic [4:0]                  s;
  logic                        bcd_zero;

  assign d        = bcd[3:0];
  assign bcd_zero = (bcd == '0);
  assign dbl      = {d, 1'b0};

  always_comb begin
    if (count[0]) begin
      v = (dbl > 5'd9) ? (dbl - 5'd9) : dbl;
    end else begin
      v = {1'b0, d};
    end
    s        = {1'b0, sum} + v;
    sum_next = (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin   <= {1'b0, card_number};
      bcd   <= '0;
      sum   <= '0;
      count <= '0;
      hi    <= '0;
      lo    <= '0;
    end else if (cmd.conv) begin
      bcd <= dabble_step(bcd, bin[lcc_pkg::BIN_W-1 -: lcc_pkg::STEP_BITS]);
      bin <= {bin[lcc_pkg::BIN_W-lcc_pkg::STEP_BITS-1:0], {lcc_pkg::STEP_BITS{1'b0}}};
    end else if (cmd.scan && !bcd_zero) begin
      bcd   <= {4'd0, bcd[lcc_pkg::BCD_W-1:4]};
      sum   <= sum_next;
      count <= count + 1'b1;
      hi    <= d;
      lo    <= hi;
    end
  end

  assign status.scan_done = bcd_zero;
  assign luhn_ok          = (sum == 4'd0);
  assign digit_count      = count;

  always_comb begin
    issuer_class = lcc_pkg::CLS_NONE;
    if (luhn_ok) begin
      if (hi == 4'd3 && (lo == 4'd4 || lo == 4'd7) && count == lcc_pkg::LEN_15) begin
        issuer_class = lcc_pkg::CLS_34_37;
      end else if (hi == 4'd5 && lo >= 4'd1 && lo <= 4'd5 && count == lcc_pkg::LEN_16) begin
        issuer_class = lcc_pkg::CLS_51_55;
      end else if (hi == 4'd4 && (count == lcc_pkg::LEN_13 || count == lcc_pkg::LEN_16)) begin
        issuer_class = lcc_pkg::CLS_LEAD4;
      end
    end
  end

endmodule

### rtl/lcc_controller.sv
// Controller: sequences load, BCD conversion and digit scan, and raises the result strobe.
// Depends on lcc_pkg; commands lcc_datapath through lcc_cmd_t.
module lcc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lcc_pkg::lcc_status_t status,
  output lcc_pkg::lcc_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [lcc_pkg::CONV_CNT_W-1:0] cnt;
  logic [lcc_pkg::CONV_CNT_W-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == lcc_pkg::CONV_CNT_W'(lcc_pkg::CONV_CYCLES - 1)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

`ifndef NO_ASSERTIONS
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_SCAN)
    else $error("result strobe not preceded by digit scan");

  a_scan_enters_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && $past(state) == ST_CONV) |-> cnt == '0)
    else $error("conversion counter did not wrap on entry to scan");

  a_conv_from_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_CONV && cnt == '0)
    else $error("load did not start conversion");
`endif

endmodule
